>>> sv/fldv_pkg.sv
// Package for the fixed-length direction vector core.
// Holds the payload and configuration types, the register map, the stage
// count and the arctangent table. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package fldv_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;

    localparam int VEC_W = 40;
    localparam int ROT_W = 48;
    localparam int ANG_W = 34;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
    localparam logic [1:0] REG_LINE_LENGTH = 2'd2;

    localparam logic signed [ANG_W-1:0] PI_UNITS = 34'sh0_8000_0000;
    localparam logic [29:0] KINV_Q30 = 30'd652032874;
    localparam logic [14:0] LENGTH_RESET = 15'd100;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
        34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4,
        34'sh028B0D43, 34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55,
        34'sh0028BE53, 34'sh00145F2F, 34'sh000A2F98, 34'sh000517CC,
        34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA, 34'sh0000517D,
        34'sh000028BE, 34'sh0000145F, 34'sh00000A30, 34'sh00000518,
        34'sh0000028C, 34'sh00000146, 34'sh000000A3, 34'sh00000051
    };

    typedef struct packed {
        logic signed [15:0] cursor_x;
        logic signed [15:0] cursor_y;
    } t_in;

    typedef struct packed {
        logic signed [15:0] direction_angle;
        logic signed [15:0] end_dx;
        logic signed [15:0] end_dy;
    } t_out;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic        [14:0] line_length;
    } t_cfg;

endpackage

`default_nettype wire

>>> sv/fldv_apb.sv
// Configuration registers of the fixed-length direction vector core.
// APB-style slave holding origin and line length; depends on fldv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fldv_apb (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [fldv_pkg::ADDR_W-1:0]  paddr,
    input  wire  [fldv_pkg::DATA_W-1:0]  pwdata,
    output logic [fldv_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output fldv_pkg::t_cfg               o_cfg
);
    import fldv_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x    <= '0;
            r_cfg.origin_y    <= '0;
            r_cfg.line_length <= LENGTH_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ORIGIN_X:    r_cfg.origin_x    <= pwdata[15:0];
                REG_ORIGIN_Y:    r_cfg.origin_y    <= pwdata[15:0];
                REG_LINE_LENGTH: r_cfg.line_length <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ORIGIN_X:    prdata = {16'd0, r_cfg.origin_x};
            REG_ORIGIN_Y:    prdata = {16'd0, r_cfg.origin_y};
            REG_LINE_LENGTH: prdata = {17'd0, r_cfg.line_length};
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/fldv_pipe.sv
// CORDIC datapath of the fixed-length direction vector core: entry stage,
// vectoring stages, rotation stages and an output stage, all advanced by one
// clock enable. Depends on fldv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fldv_pipe (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_ce,
    input  wire              i_valid,
    input  fldv_pkg::t_in    i_data,
    input  fldv_pkg::t_cfg   i_cfg,
    output logic             o_valid,
    output fldv_pkg::t_out   o_data
);
    import fldv_pkg::*;

    localparam int N = CORDIC_STAGES;

    logic [N:0] r_vvalid;
    logic [N:0] r_rvalid;
    logic       r_ovalid;

    logic signed [VEC_W-1:0] r_vx [N+1];
    logic signed [VEC_W-1:0] r_vy [N+1];
    logic signed [ANG_W-1:0] r_vz [N+1];
    logic                    r_vflip [N+1];
    logic                    r_vzero [N+1];

    logic signed [ROT_W-1:0] r_rx [N+1];
    logic signed [ROT_W-1:0] r_ry [N+1];
    logic signed [ANG_W-1:0] r_rz [N+1];
    logic signed [15:0]      r_ra [N+1];

    logic signed [ROT_W-1:0] r_kx;
    t_out                    r_o;

    logic signed [16:0]      n_dx;
    logic signed [16:0]      n_dy;
    logic signed [VEC_W-1:0] n_x;
    logic signed [VEC_W-1:0] n_y;
    logic signed [ANG_W-1:0] n_zv;
    logic signed [ANG_W-1:0] n_asum;
    logic signed [ROT_W-1:0] n_xr;
    logic signed [ROT_W-1:0] n_yr;
    logic [44:0]             n_prod;

    function automatic logic signed [15:0] clamp_q30(input logic signed [ROT_W-1:0] v);
        logic signed [ROT_W-1:0] s;
        logic signed [17:0]      q;
        begin
            s = v + ROT_W'(64'sd536870912);
            q = s[ROT_W-1:30];
            if (q > 18'sd32767) begin
                clamp_q30 = 16'sd32767;
            end else if (q < -18'sd32767) begin
                clamp_q30 = -16'sd32767;
            end else begin
                clamp_q30 = q[15:0];
            end
        end
    endfunction

    assign n_prod = i_cfg.line_length * KINV_Q30;

    always_ff @(posedge i_clk) begin
        r_kx <= {3'd0, n_prod};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vvalid <= '0;
            r_rvalid <= '0;
            r_ovalid <= 1'b0;
        end else if (i_ce) begin
            r_vvalid <= {r_vvalid[N-1:0], i_valid};
            r_rvalid <= {r_rvalid[N-1:0], r_vvalid[N]};
            r_ovalid <= r_rvalid[N];
        end
    end

    always_comb begin
        n_dx = {i_data.cursor_x[15], i_data.cursor_x} - {i_cfg.origin_x[15], i_cfg.origin_x};
        n_dy = {i_cfg.origin_y[15], i_cfg.origin_y} - {i_data.cursor_y[15], i_data.cursor_y};
        n_x  = {{3{n_dx[16]}}, n_dx, 20'd0};
        n_y  = {{3{n_dy[16]}}, n_dy, 20'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_vflip[0] <= n_dx[16];
            r_vzero[0] <= (n_dx == 17'sd0) && (n_dy == 17'sd0);
            if (n_dx[16]) begin
                r_vx[0] <= -n_x;
                r_vy[0] <= -n_y;
                r_vz[0] <= PI_UNITS;
            end else begin
                r_vx[0] <= n_x;
                r_vy[0] <= n_y;
                r_vz[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_vflip[g+1] <= r_vflip[g];
                r_vzero[g+1] <= r_vzero[g];
                if (!r_vy[g][VEC_W-1]) begin
                    r_vx[g+1] <= r_vx[g] + (r_vy[g] >>> g);
                    r_vy[g+1] <= r_vy[g] - (r_vx[g] >>> g);
                    r_vz[g+1] <= r_vz[g] + ATAN_TAB[g];
                end else begin
                    r_vx[g+1] <= r_vx[g] - (r_vy[g] >>> g);
                    r_vy[g+1] <= r_vy[g] + (r_vx[g] >>> g);
                    r_vz[g+1] <= r_vz[g] - ATAN_TAB[g];
                end
            end
        end
    end

    always_comb begin
        n_zv   = r_vzero[N] ? '0 : r_vz[N];
        n_asum = n_zv + ANG_W'(32'sd32768);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ra[0] <= n_asum[31:16];
            r_ry[0] <= '0;
            if (r_vflip[N]) begin
                r_rx[0] <= -r_kx;
                r_rz[0] <= n_zv - PI_UNITS;
            end else begin
                r_rx[0] <= r_kx;
                r_rz[0] <= n_zv;
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_ra[g+1] <= r_ra[g];
                if (!r_rz[g][ANG_W-1]) begin
                    r_rx[g+1] <= r_rx[g] - (r_ry[g] >>> g);
                    r_ry[g+1] <= r_ry[g] + (r_rx[g] >>> g);
                    r_rz[g+1] <= r_rz[g] - ATAN_TAB[g];
                end else begin
                    r_rx[g+1] <= r_rx[g] + (r_ry[g] >>> g);
                    r_ry[g+1] <= r_ry[g] - (r_rx[g] >>> g);
                    r_rz[g+1] <= r_rz[g] + ATAN_TAB[g];
                end
            end
        end
    end

    always_comb begin
        n_xr = r_rx[N];
        n_yr = r_ry[N];
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_o.direction_angle <= r_ra[N];
            r_o.end_dx          <= clamp_q30(n_xr);
            r_o.end_dy          <= clamp_q30(n_yr);
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_o;

endmodule

`default_nettype wire

>>> sv/fixed_length_direction_vector_core.sv
// Fixed-length direction vector core: from each cursor transfer it returns the atan2 angle
// of the cursor seen from the configured origin and the endpoint of a line of configured
// length pointing that way. One transfer is taken every clock cycle while the input side is
// not paused. The fully pipelined CORDIC has 16 vectoring and 16 rotation stages plus entry,
// set-up and rounding stages. A skid stage behind the output register absorbs a stall,
// after which the input side pauses until the held result is taken. Depends on fldv_pkg,
// fldv_apb and fldv_pipe.
`timescale 1ns / 1ps
`default_nettype none

module fixed_length_direction_vector_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  fldv_pkg::t_in                i_in_data,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output fldv_pkg::t_out               o_out_data,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [fldv_pkg::ADDR_W-1:0]  paddr,
    input  wire  [fldv_pkg::DATA_W-1:0]  pwdata,
    output logic [fldv_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import fldv_pkg::*;

    t_cfg w_cfg;
    logic w_ce;
    logic w_pvalid;
    t_out w_pdata;
    logic w_take;

    logic r_out_valid;
    t_out r_out;
    logic r_skid_valid;
    t_out r_skid;

    fldv_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fldv_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_cfg   (w_cfg),
        .o_valid (w_pvalid),
        .o_data  (w_pdata)
    );

    assign w_ce       = !r_skid_valid;
    assign o_in_ready = w_ce;
    assign w_take     = r_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_pvalid) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_pvalid) begin
            if (!r_out_valid || w_take) begin
                r_out <= w_pdata;
            end else begin
                r_skid <= w_pdata;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the fixed-length direction vector core. Depends on fldv_pkg
// and fixed_length_direction_vector_core; drives cursor transfers and APB register
// writes, and checks every result against a typed value or a bit-exact CORDIC predictor.
`timescale 1ns / 1ps

module testbench;

    import fldv_pkg::*;

    localparam int LATENCY        = 2 * CORDIC_STAGES + 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS  = 21;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam longint PI_ANGLE  = 64'sd2147483648;
    localparam longint GAIN_Q30  = 64'sd652032874;
    localparam longint ARCTAN_UNITS [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    typedef struct {
        t_in  cursor;
        bit   typed;
        t_out want;
    } t_probe;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    t_in                 i_in_data   = '0;
    logic                i_out_ready = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [DATA_W-1:0]   pwdata      = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    t_out                o_out_data;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    t_cfg   cfg = '{origin_x: 16'sd0, origin_y: 16'sd0, line_length: LENGTH_RESET};
    t_out   pending_vectors [$];
    t_out   want_vector;
    int     faults      = 0;
    int     idle_cycles = 0;
    bit     steady_run  = 1'b0;

    t_probe directed_rows [DIRECTED_ROWS] = '{
        '{'{16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd100, 16'sd0}},
        '{'{16'sd50, 16'sd0}, 1'b1, '{16'sd0, 16'sd100, 16'sd0}},
        '{'{16'sd0, -16'sd50}, 1'b1, '{16'sd16384, 16'sd0, 16'sd100}},
        '{'{16'sd0, 16'sd50}, 1'b1, '{-16'sd16384, 16'sd0, -16'sd100}},
        '{'{-16'sd50, 16'sd0}, 1'b1, '{16'sh8000, -16'sd100, 16'sd0}},
        '{'{-16'sd1, 16'sd0}, 1'b0, '0},
        '{'{16'sh7FFF, 16'sh7FFF}, 1'b0, '0},
        '{'{16'sh8000, 16'sh8000}, 1'b0, '0},
        '{'{16'sh7FFF, 16'sh8000}, 1'b0, '0},
        '{'{16'sh8000, 16'sh7FFF}, 1'b0, '0},
        '{'{16'sh7FFF, 16'sd0}, 1'b0, '0},
        '{'{16'sh8000, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, 16'sh8000}, 1'b0, '0},
        '{'{16'sd0, 16'sh7FFF}, 1'b0, '0},
        '{'{16'sd1, -16'sd1}, 1'b0, '0},
        '{'{-16'sd1, -16'sd1}, 1'b0, '0},
        '{'{-16'sd1, 16'sd1}, 1'b0, '0},
        '{'{16'sd1, 16'sd1}, 1'b0, '0},
        '{'{16'sd3, -16'sd4}, 1'b0, '0},
        '{'{-16'sd100, -16'sd1}, 1'b0, '0},
        '{'{-16'sd100, 16'sd1}, 1'b0, '0}
    };

    fixed_length_direction_vector_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready = steady_run || ($urandom_range(99) >= 9);
    end

    function automatic logic [15:0] round_q30(input longint v);
        longint r;
        r = (v + 64'sd536870912) >>> 30;
        if (r > 32767) r = 32767;
        else if (r < -32767) r = -32767;
        return 16'(r);
    endfunction

    function automatic t_out direction_vector_of(input t_in c);
        longint dx, dy, x, y, z, t;
        bit     flip;
        int     n, i;
        t_out   r;
        n    = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
        dx   = longint'($signed(c.cursor_x)) - longint'($signed(cfg.origin_x));
        dy   = longint'($signed(cfg.origin_y)) - longint'($signed(c.cursor_y));
        z    = 0;
        flip = 1'b0;
        if (dx != 0 || dy != 0) begin
            x = dx * 64'sd1048576;
            y = dy * 64'sd1048576;
            if (x < 0) begin
                x    = -x;
                y    = -y;
                z    = PI_ANGLE;
                flip = 1'b1;
            end
            for (i = 0; i < n; i++) begin
                t = x;
                if (y >= 0) begin
                    x += y >>> i;
                    y -= t >>> i;
                    z += ARCTAN_UNITS[i];
                end else begin
                    x -= y >>> i;
                    y += t >>> i;
                    z -= ARCTAN_UNITS[i];
                end
            end
        end
        r.direction_angle = 16'((z + 64'sd32768) >>> 16);
        x = longint'(cfg.line_length) * GAIN_Q30;
        y = 0;
        if (flip) begin
            x = -x;
            z -= PI_ANGLE;
        end
        for (i = 0; i < n; i++) begin
            t = x;
            if (z >= 0) begin
                x -= y >>> i;
                y += t >>> i;
                z -= ARCTAN_UNITS[i];
            end else begin
                x += y >>> i;
                y -= t >>> i;
                z += ARCTAN_UNITS[i];
            end
        end
        r.end_dx = round_q30(x);
        r.end_dy = round_q30(y);
        return r;
    endfunction

    function automatic t_in random_cursor();
        t_in         c;
        int          pick;
        logic [15:0] d;
        logic [15:0] edge_values [5];
        edge_values = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
        pick = $urandom_range(99);
        if (pick < 50) begin
            c = t_in'($urandom);
        end else if (pick < 70) begin
            c.cursor_x = cfg.origin_x + 16'($urandom_range(128) - 64);
            c.cursor_y = cfg.origin_y + 16'($urandom_range(128) - 64);
        end else if (pick < 80) begin
            c = t_in'($urandom);
            if ($urandom_range(1)) c.cursor_x = cfg.origin_x;
            else c.cursor_y = cfg.origin_y;
        end else if (pick < 90) begin
            d = 16'($urandom_range(2000));
            c.cursor_x = $urandom_range(1) ? cfg.origin_x + d : cfg.origin_x - d;
            c.cursor_y = $urandom_range(1) ? cfg.origin_y + d : cfg.origin_y - d;
        end else begin
            c.cursor_x = edge_values[$urandom_range(4)];
            c.cursor_y = edge_values[$urandom_range(4)];
        end
        return c;
    endfunction

    task automatic send_cursor(input t_in item, input bit typed, input t_out want);
        if (!steady_run && $urandom_range(99) < 9) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = item;
        do @(posedge i_clk); while (!o_in_ready);
        pending_vectors.push_back(typed ? want : direction_vector_of(item));
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (pending_vectors.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'({index, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (index)
            REG_ORIGIN_X:    cfg.origin_x    = value[15:0];
            REG_ORIGIN_Y:    cfg.origin_y    = value[15:0];
            REG_LINE_LENGTH: cfg.line_length = value[14:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic verify_registers();
        logic [1:0]  index;
        logic [31:0] want, mask;
        int          k;
        for (k = 0; k < 3; k++) begin
            index = 2'(k);
            case (index)
                REG_ORIGIN_X:    begin want = 32'(cfg.origin_x);    mask = 32'h0000FFFF; end
                REG_ORIGIN_Y:    begin want = 32'(cfg.origin_y);    mask = 32'h0000FFFF; end
                default:         begin want = 32'(cfg.line_length); mask = 32'h00007FFF; end
            endcase
            psel    = 1'b1;
            penable = 1'b0;
            pwrite  = 1'b0;
            paddr   = ADDR_W'({index, 2'b00});
            @(negedge i_clk);
            penable = 1'b1;
            do @(posedge i_clk); while (!pready);
            if (((prdata ^ want) & mask) != 0) begin
                $display("%0t: register %0d read back, expected %h actual %h",
                         $time, index, want & mask, prdata & mask);
                faults++;
            end
            @(negedge i_clk);
            psel    = 1'b0;
            penable = 1'b0;
        end
    endtask

    task automatic set_config(input logic [15:0] ox, input logic [15:0] oy,
                              input logic [14:0] len);
        drain_results();
        repeat (LATENCY) @(negedge i_clk);
        write_register(REG_LINE_LENGTH, {17'($urandom), len});
        write_register(REG_ORIGIN_Y, {16'($urandom), oy});
        write_register(REG_UNUSED, $urandom);
        write_register(REG_ORIGIN_X, {16'($urandom), ox});
        verify_registers();
    endtask

    task automatic run_random(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            if (k == count / 2) drain_results();
            send_cursor(random_cursor(), 1'b0, '0);
        end
    endtask

    task automatic report_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
        $display("%0t: %s expected %0d actual %0d", $time, field, $signed(want), $signed(got));
        faults++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_vectors.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none actual %h",
                         $time, o_out_data);
                faults++;
            end else begin
                want_vector = pending_vectors.pop_front();
                if (o_out_data.direction_angle !== want_vector.direction_angle)
                    report_field("direction_angle", want_vector.direction_angle,
                                 o_out_data.direction_angle);
                if (o_out_data.end_dx !== want_vector.end_dx)
                    report_field("end_dx", want_vector.end_dx, o_out_data.end_dx);
                if (o_out_data.end_dy !== want_vector.end_dy)
                    report_field("end_dy", want_vector.end_dy, o_out_data.end_dy);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int k;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        verify_registers();

        for (k = 0; k < DIRECTED_ROWS; k++)
            send_cursor(directed_rows[k].cursor, directed_rows[k].typed, directed_rows[k].want);
        run_random(280);

        set_config(16'h8000, 16'h7FFF, 15'h7FFF);
        steady_run = 1'b1;
        run_random(150);
        steady_run = 1'b0;
        run_random(150);

        set_config(16'h7FFF, 16'h8000, 15'd0);
        run_random(250);

        set_config(16'h0000, 16'h0000, 15'd1);
        run_random(250);

        for (k = 0; k < 3; k++) begin
            set_config(16'($urandom), 16'($urandom), 15'($urandom));
            run_random(280);
        end

        drain_results();
        repeat (LATENCY + 8) @(negedge i_clk);
        if (faults == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
